// File: sv/tked_pkg.sv
// ============================================================================
// tked_pkg
// Shared types and key codes for the terminal key escape decoder.
// ============================================================================
package tked_pkg;

    localparam int KIND_W = 4;
    localparam int CHAR_W = 8;

    // Key event kinds as carried on m_tuser
    localparam logic [KIND_W-1:0] KIND_CHAR       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_UP         = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DOWN       = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RIGHT      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LEFT       = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CTRL_RIGHT = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CTRL_LEFT  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ALT_BKSP   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_HOME       = 4'd10;
    localparam logic [KIND_W-1:0] KIND_END        = 4'd11;

    // One decoded key event
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
    } key_t;

    // Decoder result toward the output buffer
    typedef struct packed {
        logic valid;
        key_t key;
    } key_res_t;

endpackage

// File: sv/tked_decode.sv
// ============================================================================
// tked_decode
// Escape sequence state and per-byte decode; one byte per step.
// ============================================================================
module tked_decode #(
    parameter int SEQ_BUFFER = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    output tked_pkg::key_res_t      res
);
    import tked_pkg::*;

    localparam int SEQ_LIMIT = SEQ_BUFFER - 1;
    localparam int CW        = $clog2(SEQ_BUFFER);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_SEQ  = 2'd2;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_SS3     = 8'h4F;
    localparam logic [7:0] CH_FIN_LO  = 8'h40;
    localparam logic [7:0] CH_FIN_HI  = 8'h7E;

    logic [1:0]    phase_reg, phase_next;
    logic          bracket_reg, bracket_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    b0_reg, b0_next;
    logic [7:0]    b1_reg, b1_next;
    logic [7:0]    b2_reg, b2_next;
    logic [CW-1:0] cnt_inc;
    logic          final_byte;

    // Match the collected bytes plus the closing byte against known keys.
    // Only the first three collected bytes can matter for any known code.
    function automatic logic [KIND_W-1:0] match_seq(
        input logic          brk,
        input logic [CW-1:0] cnt,
        input logic [7:0]    s0,
        input logic [7:0]    s1,
        input logic [7:0]    s2,
        input logic [7:0]    last
    );
        logic [KIND_W-1:0] k;
        k = KIND_UNKNOWN;
        if (cnt == CW'(0)) begin
            case (last)
                "A":     k = KIND_UP;
                "B":     k = KIND_DOWN;
                "C":     k = KIND_RIGHT;
                "D":     k = KIND_LEFT;
                "H":     k = KIND_HOME;
                "F":     k = KIND_END;
                default: k = KIND_UNKNOWN;
            endcase
        end else if (brk && cnt == CW'(1)) begin
            case ({s0, last})
                "1~", "7~": k = KIND_HOME;
                "4~", "8~": k = KIND_END;
                "3~":       k = KIND_DELETE;
                "5C":       k = KIND_CTRL_RIGHT;
                "5D":       k = KIND_CTRL_LEFT;
                default:    k = KIND_UNKNOWN;
            endcase
        end else if (brk && cnt == CW'(3) && {s0, s1, s2} == "1;5") begin
            case (last)
                "C":     k = KIND_CTRL_RIGHT;
                "D":     k = KIND_CTRL_LEFT;
                default: k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

    assign cnt_inc    = cnt_reg + CW'(1);
    assign final_byte = (in_byte >= CH_FIN_LO) && (in_byte <= CH_FIN_HI);

    // Per-byte decode
    always_comb begin
        phase_next   = phase_reg;
        bracket_next = bracket_reg;
        cnt_next     = cnt_reg;
        b0_next      = b0_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        res.valid    = 1'b0;
        res.key.kind = KIND_CHAR;
        res.key.ch   = 8'd0;
        case (phase_reg)
            PH_ESC: begin
                phase_next = PH_IDLE;
                if (in_byte == CH_DEL || in_byte == CH_BS) begin
                    res.valid    = 1'b1;
                    res.key.kind = KIND_ALT_BKSP;
                end else if (in_byte == CH_BRACKET || in_byte == CH_SS3) begin
                    bracket_next = (in_byte == CH_BRACKET);
                    cnt_next     = '0;
                    phase_next   = PH_SEQ;
                end else begin
                    res.valid    = 1'b1;
                    res.key.kind = KIND_UNKNOWN;
                end
            end
            PH_SEQ: begin
                // count is always below the limit here
                if (cnt_reg == CW'(0)) b0_next = in_byte;
                if (cnt_reg == CW'(1)) b1_next = in_byte;
                if (cnt_reg == CW'(2)) b2_next = in_byte;
                cnt_next = cnt_inc;
                if (final_byte || cnt_inc == CW'(SEQ_LIMIT)) begin
                    phase_next   = PH_IDLE;
                    res.valid    = 1'b1;
                    res.key.kind = match_seq(bracket_reg, cnt_reg, b0_reg, b1_reg,
                                             b2_reg, in_byte);
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (in_byte == CH_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    res.valid    = 1'b1;
                    res.key.kind = KIND_CHAR;
                    res.key.ch   = (in_byte == CH_CR) ? CH_LF : in_byte;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bracket_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            bracket_reg <= bracket_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Collected sequence bytes
    always_ff @(posedge aclk) begin
        if (step) begin
            b0_reg <= b0_next;
            b1_reg <= b1_next;
            b2_reg <= b2_next;
        end
    end

    // While collecting, the count stays below the limit
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SEQ) |-> (cnt_reg < CW'(SEQ_LIMIT)))
        else $error("sequence count at or past limit while collecting");

    // An ESC byte in idle only opens a sequence
    a_esc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_IDLE && in_byte == CH_ESC) |=> (phase_reg == PH_ESC))
        else $error("ESC in idle did not enter ESC phase");

    // A byte seen after ESC never yields a char event
    a_esc_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ESC && res.valid) |-> (res.key.kind != KIND_CHAR))
        else $error("char event after ESC");

endmodule

// File: sv/tked_outbuf.sv
// ============================================================================
// tked_outbuf
// Two-entry output buffer; keeps input flowing while a result waits.
// ============================================================================
module tked_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tked_pkg::key_t    push_key,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output tked_pkg::key_t    out_key
);
    import tked_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    key_t       e0_reg, e0_next;
    key_t       e1_reg, e1_next;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_key   = e0_reg;
    assign pop       = out_valid && out_ready;

    // Entry 0 is the head beat
    always_comb begin
        cnt_next = cnt_reg;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) e0_next = push_key;
                else                 e1_next = push_key;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                e0_next  = e1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    e0_next = push_key;
                end else begin
                    e0_next = e1_reg;
                    e1_next = push_key;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full output buffer");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1 && pop && !push) |=> !out_valid)
        else $error("buffer not empty after draining last beat");

endmodule

// File: sv/terminal_key_escape_decoder_core.sv
// ============================================================================
// terminal_key_escape_decoder_core
// Decodes terminal input bytes into key events (ANSI/VT100 escape codes).
// ============================================================================
// One input byte is taken per cycle on the s_ stream; each byte yields zero
// or one key event on the m_ stream, pushed into the output buffer when the
// byte is accepted. Sustained rate is one byte per clock: the per-byte
// decode is a single pass of logic into a two-entry output buffer, and
// s_tready drops only while both buffer entries hold results the sink has
// not taken. Carriage return comes out as line feed; ESC sequences that do
// not match a known key report kind unknown. SEQ_BUFFER sets the escape
// sequence length limit (SEQ_BUFFER-1 bytes after the prefix).
module terminal_key_escape_decoder_core #(
    parameter int SEQ_BUFFER = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] key_char
    output logic [3:0]  m_tuser    // [3:0] key_kind
);
    import tked_pkg::*;

    logic     full;
    logic     step;
    key_res_t res;
    key_t     head;

    assign s_tready = !full;
    assign step     = s_tvalid && s_tready;

    // Byte decode and sequence state
    tked_decode #(
        .SEQ_BUFFER (SEQ_BUFFER)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (s_tdata),
        .res     (res)
    );

    // Result buffer
    tked_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res.valid),
        .push_key  (res.key),
        .full      (full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_key   (head)
    );

    assign m_tdata = head.ch;
    assign m_tuser = head.kind;

endmodule
